// ----- sv/stbs_pkg.sv -----
// Shared types and constants for the sorted table binary search block.
// No dependencies; imported by stbs_search, the top level and the checker.
package stbs_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int KEY_W       = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADDR,
		ST_CMP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} rd_req_t;

	typedef struct packed {
		logic             found;
		logic [CNT_W-1:0] position;
	} result_t;

endpackage

// ----- sv/stbs_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/stbs_search.sv -----
// Search sequencer: bounds registers, midpoint adder and the key comparators (equal, signed less-than).
// Depends on stbs_pkg; reads the table through the top level's RAM port.
module stbs_search (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [stbs_pkg::KEY_W-1:0] key,
	input  logic [stbs_pkg::CNT_W-1:0] count,
	input  logic [stbs_pkg::KEY_W-1:0] rdata,
	input  logic                       res_take,
	output stbs_pkg::rd_req_t          rd,
	output stbs_pkg::result_t          res,
	output logic                       res_valid,
	output logic                       idle
);
	import stbs_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] left_q, rexcl_q;
	logic [IDX_W-1:0] mid_q;
	logic [KEY_W-1:0] key_q;
	result_t          res_q;
	logic [CNT_W:0]   sum;
	logic [IDX_W-1:0] mid;
	logic             empty;
	logic             eq, lt;

	assign sum   = {1'b0, left_q} + {1'b0, rexcl_q} - (CNT_W+1)'(1);
	assign mid   = sum[IDX_W:1];
	assign empty = (left_q >= rexcl_q);
	assign eq    = (rdata == key_q);
	assign lt    = ($signed(rdata) < $signed(key_q));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_ADDR;
			ST_ADDR: state_d = empty ? ST_FIN : ST_CMP;
			ST_CMP:  state_d = eq ? ST_FIN : ST_ADDR;
			ST_FIN:  if (res_take) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rd.en     = (state_q == ST_ADDR) && !empty;
		rd.addr   = mid;
		res       = res_q;
		res_valid = (state_q == ST_FIN);
		idle      = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					key_q   <= key;
					left_q  <= '0;
					rexcl_q <= count;
				end
			end
			ST_ADDR: begin
				mid_q <= mid;
				if (empty) begin
					res_q.found    <= 1'b0;
					res_q.position <= left_q;
				end
			end
			ST_CMP: begin
				if (eq) begin
					res_q.found    <= 1'b1;
					res_q.position <= CNT_W'(mid_q);
				end else if (lt) begin
					left_q <= CNT_W'(mid_q) + CNT_W'(1);
				end else begin
					rexcl_q <= CNT_W'(mid_q);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- sv/sorted_table_binary_search.sv -----
// Top level of the sorted table binary search block.
// Depends on stbs_pkg, stbs_ram and stbs_search.
//
// Usage:
//   Input channel (in_valid/in_ready): kind selects a table write (entry_index,
//   key_value) or a search for key_value. A write is stored in the transfer cycle
//   and returns nothing. A search returns one result on the output channel
//   (out_valid/out_ready): found and position (match index, else insertion point).
//   Configuration channel (cfg_valid/cfg_ready): cfg_data sets entry_count, the
//   number of entries (ascending in signed order) searched; values above the depth are clamped.
//   Write it only while the block is idle.
// Search sequence:
//   Each probe is a RAM read (ST_ADDR), then a compare (ST_CMP); a search makes
//   at most floor(log2(entry_count))+1 probes, then offers its result in ST_FIN.
//   in_ready returns with out_valid, so a new search cannot start before the
//   sequencer hands its result to the output register. The single RAM port and
//   the comparators set this; in_ready is low while a search runs.
// Reset: arst_n clears the count to zero and the sequencer to idle; the table
//   contents are undefined until written.
// Stall: the result waits in an output register; the sequencer holds its
//   finished result until that register is free.
module sorted_table_binary_search (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       kind,
	input  logic [stbs_pkg::IDX_W-1:0] entry_index,
	input  logic [stbs_pkg::KEY_W-1:0] key_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       found,
	output logic [stbs_pkg::CNT_W-1:0] position,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [stbs_pkg::CNT_W-1:0] cfg_data
);
	import stbs_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_sat;
	logic             out_valid_q;
	result_t          out_q;
	rd_req_t          rd;
	result_t          res;
	logic             res_valid, res_take, idle;
	logic             in_xfer, wr_en, start;
	logic [IDX_W-1:0] ram_addr;
	logic [KEY_W-1:0] rdata;

	assign cfg_ready = 1'b1;
	assign in_ready  = idle;
	assign in_xfer   = in_valid && in_ready;
	assign wr_en     = in_xfer && (kind == KIND_WRITE);
	assign start     = in_xfer && (kind == KIND_SEARCH);
	assign count_sat = (count_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_q;
	assign ram_addr  = wr_en ? entry_index : rd.addr;
	assign res_take  = res_valid && (!out_valid_q || out_ready);

	stbs_ram #(
		.WIDTH(KEY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.addr (ram_addr),
		.wdata(key_value),
		.rdata(rdata)
	);

	stbs_search u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.key      (key_value),
		.count    (count_sat),
		.rdata    (rdata),
		.res_take (res_take),
		.rd       (rd),
		.res      (res),
		.res_valid(res_valid),
		.idle     (idle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			if (res_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = out_q.found;
	assign position  = out_q.position;

endmodule

// ----- sv/stbs_chk.sv -----
// Port-level checker for sorted_table_binary_search, attached by bind.
// Depends on stbs_pkg.
module stbs_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       kind,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       found,
	input logic [stbs_pkg::CNT_W-1:0] position
);
	import stbs_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(position))
		else $error("result changed or dropped while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (kind == KIND_SEARCH) |=> !in_ready)
		else $error("input ready during a search");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (kind == KIND_WRITE) && !out_valid |=> !out_valid)
		else $error("write produced a result");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (position <= CNT_W'(TABLE_DEPTH)) &&
			(!found || (position < CNT_W'(TABLE_DEPTH))))
		else $error("position out of range");

endmodule

bind sorted_table_binary_search stbs_chk u_stbs_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.kind     (kind),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.found    (found),
	.position (position)
);
